// ===== sv/sfcf_pkg.sv =====
`timescale 1ns / 1ps
package sfcf_pkg;

  // ring sizes; each ring holds one less byte than its depth
  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);

  localparam int BYTE_W = 8;
  localparam int FUNC_W = 3;
  localparam int CMD_W = 3;
  localparam int REG_IDX_W = 2;

  // event kinds
  localparam logic [FUNC_W-1:0] FUNC_RX_BYTE    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_HOST_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_HOST_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TX_READY   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH_RX   = 3'd4;

  // command event codes
  localparam logic [CMD_W-1:0] EVT_NONE        = 3'd0;
  localparam logic [CMD_W-1:0] EVT_STATUS      = 3'd1;
  localparam logic [CMD_W-1:0] EVT_CYCLE_START = 3'd2;
  localparam logic [CMD_W-1:0] EVT_FEED_HOLD   = 3'd3;
  localparam logic [CMD_W-1:0] EVT_SYS_RESET   = 3'd4;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_STATUS_CHAR      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CYCLE_START_CHAR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FEED_HOLD_CHAR   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RESET_CHAR       = 2'd3;

  localparam logic [BYTE_W-1:0] STATUS_CHAR_RST      = 8'd63;
  localparam logic [BYTE_W-1:0] CYCLE_START_CHAR_RST = 8'd126;
  localparam logic [BYTE_W-1:0] FEED_HOLD_CHAR_RST   = 8'd33;
  localparam logic [BYTE_W-1:0] RESET_CHAR_RST       = 8'd24;

endpackage

// ===== sv/sfcf_ram.sv =====
`timescale 1ns / 1ps
module sfcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/serial_fifo_command_filter.sv =====
`timescale 1ns / 1ps
// serial receive/transmit ring buffers with a realtime command filter
//
// input channel (in_valid / in_stall) carries one event per transaction:
// func selects rx byte, host read, host write, tx ready or rx flush, and
// data_in carries the byte for rx byte and host write.
// output channel (out_valid / out_stall) returns exactly one result
// transaction per event, in order.
// most events return their result from the output register in the cycle
// after acceptance; a host read that finds data and a tx ready that finds
// a queued byte read a ring memory and return after a wait state.
// throughput: one event per cycle while the receiver does not stall; the
// input stalls during the wait state of those ring reads.
// the result sits in an output register; a new event is accepted in the
// cycle that register is taken, so a stalling receiver holds the result
// and stalls the input side only while the result is waiting.
// config writes (cfg_we / cfg_index / cfg_data) set the four command
// characters and are expected only while the block is idle.
// reset (synchronous, active high) empties both rings, marks the
// transmitter idle and restores the default command characters.
module serial_fifo_command_filter (
  input  logic                               clk,
  input  logic                               rst,
  // event input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sfcf_pkg::FUNC_W-1:0]        func,
  input  logic [sfcf_pkg::BYTE_W-1:0]        data_in,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               read_valid,
  output logic [sfcf_pkg::BYTE_W-1:0]        read_data,
  output logic                               tx_valid,
  output logic [sfcf_pkg::BYTE_W-1:0]        tx_data,
  output logic [sfcf_pkg::CMD_W-1:0]         command_event,
  output logic                               rx_dropped,
  output logic                               write_refused,
  // configuration
  input  logic                               cfg_we,
  input  logic [sfcf_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [sfcf_pkg::BYTE_W-1:0]        cfg_data
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RDWAIT = 1'b1;

  // command characters
  logic [sfcf_pkg::BYTE_W-1:0] status_char;
  logic [sfcf_pkg::BYTE_W-1:0] cycle_start_char;
  logic [sfcf_pkg::BYTE_W-1:0] feed_hold_char;
  logic [sfcf_pkg::BYTE_W-1:0] reset_char;

  // ring pointers
  logic [sfcf_pkg::RX_AW-1:0] rx_head, rx_head_next;
  logic [sfcf_pkg::RX_AW-1:0] rx_tail, rx_tail_next;
  logic [sfcf_pkg::TX_AW-1:0] tx_head, tx_head_next;
  logic [sfcf_pkg::TX_AW-1:0] tx_tail, tx_tail_next;
  logic                       tx_busy, tx_busy_next;

  logic state, state_next;
  logic rd_from_rx, rd_from_rx_next;   // pending read targets rx ring

  // result fields computed at acceptance
  logic                          res_read_valid;
  logic                          res_tx_valid;
  logic [sfcf_pkg::BYTE_W-1:0]   res_tx_data;
  logic [sfcf_pkg::CMD_W-1:0]    res_cmd;
  logic                          res_dropped;
  logic                          res_refused;
  logic                          res_needs_read;

  // memory ports
  logic                          rx_we, rx_re;
  logic                          tx_we, tx_re;
  logic [sfcf_pkg::BYTE_W-1:0]   rx_rdata, tx_rdata;

  logic in_acc, out_take;
  logic [sfcf_pkg::RX_AW-1:0] rx_head_inc, rx_tail_inc;
  logic [sfcf_pkg::TX_AW-1:0] tx_head_inc, tx_tail_inc;
  logic rx_full, rx_empty, tx_full, tx_empty;

  // stall input while a read is in flight or the result is held
  assign in_stall = (state == ST_RDWAIT) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // wrapping increments work for any depth, not just powers of two
  assign rx_head_inc = (rx_head == sfcf_pkg::RX_AW'(sfcf_pkg::RX_DEPTH - 1))
                       ? '0 : rx_head + 1'b1;
  assign rx_tail_inc = (rx_tail == sfcf_pkg::RX_AW'(sfcf_pkg::RX_DEPTH - 1))
                       ? '0 : rx_tail + 1'b1;
  assign tx_head_inc = (tx_head == sfcf_pkg::TX_AW'(sfcf_pkg::TX_DEPTH - 1))
                       ? '0 : tx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == sfcf_pkg::TX_AW'(sfcf_pkg::TX_DEPTH - 1))
                       ? '0 : tx_tail + 1'b1;

  assign rx_full  = (rx_head_inc == rx_tail);
  assign rx_empty = (rx_head == rx_tail);
  assign tx_full  = (tx_head_inc == tx_tail);
  assign tx_empty = (tx_head == tx_tail);

  // event decode: pointer updates, memory accesses and result fields
  always_comb begin
    rx_head_next    = rx_head;
    rx_tail_next    = rx_tail;
    tx_head_next    = tx_head;
    tx_tail_next    = tx_tail;
    tx_busy_next    = tx_busy;
    rx_we           = 1'b0;
    rx_re           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    res_read_valid  = 1'b0;
    res_tx_valid    = 1'b0;
    res_tx_data     = '0;
    res_cmd         = sfcf_pkg::EVT_NONE;
    res_dropped     = 1'b0;
    res_refused     = 1'b0;
    res_needs_read  = 1'b0;
    if (in_acc) begin
      case (func)
        sfcf_pkg::FUNC_RX_BYTE: begin
          // first matching command character wins
          if (data_in == status_char) begin
            res_cmd = sfcf_pkg::EVT_STATUS;
          end else if (data_in == cycle_start_char) begin
            res_cmd = sfcf_pkg::EVT_CYCLE_START;
          end else if (data_in == feed_hold_char) begin
            res_cmd = sfcf_pkg::EVT_FEED_HOLD;
          end else if (data_in == reset_char) begin
            res_cmd = sfcf_pkg::EVT_SYS_RESET;
          end else if (rx_full) begin
            res_dropped = 1'b1;
          end else begin
            rx_we        = 1'b1;
            rx_head_next = rx_head_inc;
          end
        end
        sfcf_pkg::FUNC_HOST_READ: begin
          if (!rx_empty) begin
            rx_re          = 1'b1;
            res_read_valid = 1'b1;
            res_needs_read = 1'b1;
            rx_tail_next   = rx_tail_inc;
          end
        end
        sfcf_pkg::FUNC_HOST_WRITE: begin
          // fullness is tested before the idle check
          if (tx_full) begin
            res_refused = 1'b1;
          end else if (tx_busy) begin
            tx_we        = 1'b1;
            tx_head_next = tx_head_inc;
          end else begin
            tx_busy_next = 1'b1;
            res_tx_valid = 1'b1;
            res_tx_data  = data_in;
          end
        end
        sfcf_pkg::FUNC_TX_READY: begin
          if (!tx_empty) begin
            tx_re          = 1'b1;
            res_tx_valid   = 1'b1;
            res_needs_read = 1'b1;
            tx_tail_next   = tx_tail_inc;
          end else begin
            tx_busy_next = 1'b0;
          end
        end
        sfcf_pkg::FUNC_FLUSH_RX: begin
          rx_tail_next = rx_head;
        end
        default: begin
          // unknown event: all-zero result
        end
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    rd_from_rx_next = rd_from_rx;
    case (state)
      ST_IDLE: begin
        if (in_acc && res_needs_read) begin
          state_next      = ST_RDWAIT;
          rd_from_rx_next = res_read_valid;
        end
      end
      ST_RDWAIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head    <= '0;
      rx_tail    <= '0;
      tx_head    <= '0;
      tx_tail    <= '0;
      tx_busy    <= 1'b0;
      state      <= ST_IDLE;
      rd_from_rx <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rx_head    <= rx_head_next;
      rx_tail    <= rx_tail_next;
      tx_head    <= tx_head_next;
      tx_tail    <= tx_tail_next;
      tx_busy    <= tx_busy_next;
      state      <= state_next;
      rd_from_rx <= rd_from_rx_next;
      if (in_acc) begin
        // events that read a ring memory raise out_valid from the wait state instead
        out_valid <= !res_needs_read;
      end else if (state == ST_RDWAIT) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command characters
  always_ff @(posedge clk) begin
    if (rst) begin
      status_char      <= sfcf_pkg::STATUS_CHAR_RST;
      cycle_start_char <= sfcf_pkg::CYCLE_START_CHAR_RST;
      feed_hold_char   <= sfcf_pkg::FEED_HOLD_CHAR_RST;
      reset_char       <= sfcf_pkg::RESET_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sfcf_pkg::REG_STATUS_CHAR:      status_char      <= cfg_data;
        sfcf_pkg::REG_CYCLE_START_CHAR: cycle_start_char <= cfg_data;
        sfcf_pkg::REG_FEED_HOLD_CHAR:   feed_hold_char   <= cfg_data;
        sfcf_pkg::REG_RESET_CHAR:       reset_char       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result payload register; read bytes land in the wait cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      read_valid    <= res_read_valid;
      read_data     <= '0;
      tx_valid      <= res_tx_valid;
      tx_data       <= res_tx_data;
      command_event <= res_cmd;
      rx_dropped    <= res_dropped;
      write_refused <= res_refused;
    end else if (state == ST_RDWAIT) begin
      if (rd_from_rx) begin
        read_data <= rx_rdata;
      end else begin
        tx_data <= tx_rdata;
      end
    end
  end

  sfcf_ram #(
    .WIDTH (sfcf_pkg::BYTE_W),
    .DEPTH (sfcf_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head),
    .wdata (data_in),
    .re    (rx_re),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  sfcf_ram #(
    .WIDTH (sfcf_pkg::BYTE_W),
    .DEPTH (sfcf_pkg::TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head),
    .wdata (data_in),
    .re    (tx_re),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  // no input transaction while a ring read is outstanding
  a_wait_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDWAIT) |-> in_stall)
    else $error("input accepted during ring read");

  // a host read that hits the ring delivers its result after the wait cycle
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    (in_acc && func == sfcf_pkg::FUNC_HOST_READ && rx_head != rx_tail)
    |=> (state == ST_RDWAIT && !out_valid) ##1 (out_valid && read_valid))
    else $error("host read result not delivered after wait");

  // a result reports at most one kind of outcome
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({read_valid, tx_valid, rx_dropped, write_refused,
                            command_event != sfcf_pkg::EVT_NONE}))
    else $error("result carries more than one outcome");

  // the transmitter goes idle only on a tx ready event or on reset
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(tx_busy) |-> ($past(rst) || $past(in_acc && func == sfcf_pkg::FUNC_TX_READY)))
    else $error("transmitter marked idle without tx ready");

endmodule

// ===== dv/sfcf_tb_pkg.sv =====
`timescale 1ns / 1ps
package sfcf_tb_pkg;

  import sfcf_pkg::*;

  typedef struct packed {
    logic               read_valid;
    logic [BYTE_W-1:0]  read_data;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_data;
    logic [CMD_W-1:0]   command_event;
    logic               rx_dropped;
    logic               write_refused;
  } filter_result_t;

  class serial_event_checker;

    localparam int MAX_REPORTED = 30;

    logic [BYTE_W-1:0] status_ch;
    logic [BYTE_W-1:0] cycle_start_ch;
    logic [BYTE_W-1:0] feed_hold_ch;
    logic [BYTE_W-1:0] reset_ch;

    logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
    logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
    logic [RX_AW-1:0]  rx_head;
    logic [RX_AW-1:0]  rx_tail;
    logic [TX_AW-1:0]  tx_head;
    logic [TX_AW-1:0]  tx_tail;
    logic              tx_busy;

    filter_result_t awaited[$];

    int errors;
    int n_events;
    int n_commands;
    int n_dropped;
    int n_popped;
    int n_sent;
    int n_refused;

    function new();
      set_chars(STATUS_CHAR_RST, CYCLE_START_CHAR_RST, FEED_HOLD_CHAR_RST, RESET_CHAR_RST);
      rx_head = '0;
      rx_tail = '0;
      tx_head = '0;
      tx_tail = '0;
      tx_busy = 1'b0;
      errors = 0;
      n_events = 0;
      n_commands = 0;
      n_dropped = 0;
      n_popped = 0;
      n_sent = 0;
      n_refused = 0;
    endfunction

    function void set_chars(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] c,
                            logic [BYTE_W-1:0] f, logic [BYTE_W-1:0] r);
      status_ch = s;
      cycle_start_ch = c;
      feed_hold_ch = f;
      reset_ch = r;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [RX_AW-1:0] next_rx(logic [RX_AW-1:0] idx);
      return (idx == RX_AW'(RX_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function logic [TX_AW-1:0] next_tx(logic [TX_AW-1:0] idx);
      return (idx == TX_AW'(TX_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function string describe(filter_result_t r);
      return $sformatf("rv=%0b rd=%02h tv=%0b td=%02h cmd=%0d drop=%0b refused=%0b",
                       r.read_valid, r.read_data, r.tx_valid, r.tx_data,
                       r.command_event, r.rx_dropped, r.write_refused);
    endfunction

    // predicts the result of one accepted event and queues it
    function void note_event(logic [FUNC_W-1:0] kind, logic [BYTE_W-1:0] payload);
      filter_result_t r;
      r = '0;
      n_events++;
      case (kind)
        FUNC_RX_BYTE: begin
          if (payload == status_ch) r.command_event = EVT_STATUS;
          else if (payload == cycle_start_ch) r.command_event = EVT_CYCLE_START;
          else if (payload == feed_hold_ch) r.command_event = EVT_FEED_HOLD;
          else if (payload == reset_ch) r.command_event = EVT_SYS_RESET;
          else if (next_rx(rx_head) == rx_tail) r.rx_dropped = 1'b1;
          else begin
            rx_ring[rx_head] = payload;
            rx_head = next_rx(rx_head);
          end
        end
        FUNC_HOST_READ: begin
          if (rx_head != rx_tail) begin
            r.read_valid = 1'b1;
            r.read_data = rx_ring[rx_tail];
            rx_tail = next_rx(rx_tail);
          end
        end
        FUNC_HOST_WRITE: begin
          if (next_tx(tx_head) == tx_tail) r.write_refused = 1'b1;
          else if (tx_busy) begin
            tx_ring[tx_head] = payload;
            tx_head = next_tx(tx_head);
          end else begin
            tx_busy = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_data = payload;
          end
        end
        FUNC_TX_READY: begin
          if (tx_head != tx_tail) begin
            r.tx_valid = 1'b1;
            r.tx_data = tx_ring[tx_tail];
            tx_tail = next_tx(tx_tail);
          end else begin
            tx_busy = 1'b0;
          end
        end
        FUNC_FLUSH_RX: rx_tail = rx_head;
        default: ;
      endcase
      if (r.command_event != EVT_NONE) n_commands++;
      if (r.rx_dropped) n_dropped++;
      if (r.read_valid) n_popped++;
      if (r.tx_valid) n_sent++;
      if (r.write_refused) n_refused++;
      awaited.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(filter_result_t got);
      filter_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch({"result with nothing outstanding: ", describe(got)});
        return;
      end
      want = awaited.pop_front();
      if (got !== want)
        report_mismatch({"got ", describe(got), " expected ", describe(want)});
    endtask

  endclass

endpackage

// ===== dv/tb_serial_fifo_command_filter.sv =====
`timescale 1ns / 1ps
module tb_serial_fifo_command_filter;

  import sfcf_pkg::*;
  import sfcf_tb_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 7;
  // nothing accepted for this long means the block is hung
  localparam int QUIET_LIMIT     = 2000;
  // long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 60;
  // worst result latency is a ring read through the wait state, leave some slack
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 130;

  // every block input starts at a known value
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func = FUNC_RX_BYTE;
  logic [BYTE_W-1:0]  data_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               read_valid;
  logic [BYTE_W-1:0]  read_data;
  logic               tx_valid;
  logic [BYTE_W-1:0]  tx_data;
  logic [CMD_W-1:0]   command_event;
  logic               rx_dropped;
  logic               write_refused;
  logic               cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_STATUS_CHAR;
  logic [BYTE_W-1:0]  cfg_data = '0;

  // idle odds in percent for each side, changed per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // bumped by the stimulus, served by the receiver process
  int hold_requests = 0;
  int sent_items = 0;

  serial_event_checker filter_sb;

  serial_fifo_command_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .data_in      (data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_valid   (read_valid),
    .read_data    (read_data),
    .tx_valid     (tx_valid),
    .tx_data      (tx_data),
    .command_event(command_event),
    .rx_dropped   (rx_dropped),
    .write_refused(write_refused),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial filter_sb = new();

  // monitor: predict on every accepted event, check every accepted result
  // both sides are sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) filter_sb.note_event(func, data_in);
      if (out_valid && !out_stall)
        filter_sb.check_result(filter_result_t'{read_valid, read_data, tx_valid, tx_data,
                                                command_event, rx_dropped, write_refused});
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    int served;
    int left;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests > served) begin
        served++;
        left = HOLD_OFF_CYCLES;
        out_stall <= 1'b1;
        while (left > 1) begin
          @(posedge clk);
          left--;
        end
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel or config port
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles, %0d results outstanding",
             QUIET_LIMIT, filter_sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  // one event transaction, with random sender gaps in front of it
  task automatic send_event(input logic [FUNC_W-1:0] kind, input logic [BYTE_W-1:0] payload);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= kind;
    data_in <= payload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // stop offering and wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filter_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high; set_chars lowers it after the last write
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_chars(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] c,
                           input logic [BYTE_W-1:0] f, input logic [BYTE_W-1:0] r);
    write_reg(REG_STATUS_CHAR, s);
    write_reg(REG_CYCLE_START_CHAR, c);
    write_reg(REG_FEED_HOLD_CHAR, f);
    write_reg(REG_RESET_CHAR, r);
    cfg_we <= 1'b0;
    filter_sb.set_chars(s, c, f, r);
  endtask

  // received byte: a command character now and then, otherwise any value
  function automatic logic [BYTE_W-1:0] pick_rx_byte(input int cmd_pct);
    if ($urandom_range(99) >= cmd_pct) return BYTE_W'($urandom_range(255));
    case (REG_IDX_W'($urandom_range(3)))
      REG_STATUS_CHAR:      return filter_sb.status_ch;
      REG_CYCLE_START_CHAR: return filter_sb.cycle_start_ch;
      REG_FEED_HOLD_CHAR:   return filter_sb.feed_hold_ch;
      default:              return filter_sb.reset_ch;
    endcase
  endfunction

  task automatic rx_burst(input int n, input int cmd_pct);
    repeat (n) send_event(FUNC_RX_BYTE, pick_rx_byte(cmd_pct));
  endtask

  task automatic repeat_event(input logic [FUNC_W-1:0] kind, input int n);
    repeat (n) send_event(kind, BYTE_W'($urandom_range(255)));
  endtask

  // mostly runs of one event kind so the rings fill and empty for real,
  // plus flushes and a little noise including the unused function codes
  task automatic run_random(input int goal);
    int pick;
    while (sent_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 30) rx_burst($urandom_range(1, 12), 15);
      else if (pick < 48) repeat_event(FUNC_HOST_READ, $urandom_range(1, 10));
      else if (pick < 66) repeat_event(FUNC_HOST_WRITE, $urandom_range(1, 8));
      else if (pick < 84) repeat_event(FUNC_TX_READY, $urandom_range(1, 8));
      else if (pick < 90) send_event(FUNC_FLUSH_RX, BYTE_W'($urandom_range(255)));
      else send_event(FUNC_W'($urandom_range(2 ** FUNC_W - 1)), BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part, default command characters
    send_event(FUNC_HOST_READ, 8'h00);      // read of an empty ring
    send_event(FUNC_TX_READY, 8'h00);       // ready with nothing queued
    send_event(FUNC_RX_BYTE, 8'h00);
    send_event(FUNC_RX_BYTE, 8'hFF);
    send_event(FUNC_RX_BYTE, STATUS_CHAR_RST);
    send_event(FUNC_RX_BYTE, CYCLE_START_CHAR_RST);
    send_event(FUNC_RX_BYTE, FEED_HOLD_CHAR_RST);
    send_event(FUNC_RX_BYTE, RESET_CHAR_RST);
    send_event(FUNC_HOST_READ, 8'hFF);
    send_event(FUNC_HOST_READ, 8'hFF);
    send_event(FUNC_HOST_WRITE, 8'hA5);     // idle transmitter, goes straight out
    send_event(FUNC_HOST_WRITE, 8'h5A);     // transmitter busy, gets queued
    send_event(FUNC_TX_READY, 8'hFF);       // sends the queued byte
    send_event(FUNC_TX_READY, 8'h00);       // queue empty, transmitter goes idle
    // unused function codes are ignored
    for (int k = FUNC_FLUSH_RX + 1; k < 2 ** FUNC_W; k++) send_event(FUNC_W'(k), 8'hFF);
    send_event(FUNC_RX_BYTE, 8'h11);
    send_event(FUNC_FLUSH_RX, 8'h00);
    send_event(FUNC_HOST_READ, 8'h00);      // flushed ring reads empty

    // all four characters equal: status has priority
    drain();
    set_chars(8'h41, 8'h41, 8'h41, 8'h41);
    send_event(FUNC_RX_BYTE, 8'h41);
    // extreme character values, overlapping pairs
    drain();
    set_chars(8'h00, 8'hFF, 8'hFF, 8'h00);
    send_event(FUNC_RX_BYTE, 8'h00);
    send_event(FUNC_RX_BYTE, 8'hFF);
    drain();
    set_chars(8'h00, 8'hFF, 8'h80, 8'h7F);
    send_event(FUNC_RX_BYTE, 8'h80);
    send_event(FUNC_RX_BYTE, 8'h7F);

    // phase one: sender mostly busy, receiver mostly stalling,
    // opened by a long hold-off while the sender keeps offering
    drain();
    tx_idle_pct = 18;
    rx_idle_pct = 85;
    hold_requests++;
    run_random(sent_items + PHASE_ITEMS);

    // phase two: random characters, the idle odds swapped
    drain();
    set_chars(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
    tx_idle_pct = 85;
    rx_idle_pct = 18;
    run_random(sent_items + PHASE_ITEMS);

    // phase three: back to default characters, no idling; overflow both
    // rings first, then another hold-off and random traffic
    drain();
    set_chars(STATUS_CHAR_RST, CYCLE_START_CHAR_RST, FEED_HOLD_CHAR_RST, RESET_CHAR_RST);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_burst(RX_DEPTH + 16, 3);
    repeat_event(FUNC_HOST_WRITE, TX_DEPTH + 4);
    send_event(FUNC_FLUSH_RX, 8'h00);
    hold_requests++;
    run_random(sent_items + PHASE_ITEMS);

    drain();
    $display("covered %0d event transactions: %0d command bytes, %0d bytes dropped",
             filter_sb.n_events, filter_sb.n_commands, filter_sb.n_dropped);
    $display("%0d host reads with data, %0d bytes handed to the transmitter",
             filter_sb.n_popped, filter_sb.n_sent);
    $display("%0d host writes refused, %0d mismatches",
             filter_sb.n_refused, filter_sb.errors);
    if (filter_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
